>>> rtl/core/qtt_pkg.sv
`timescale 1ns / 1ps

package qtt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_NUM   = 3'd3,
    MODE_IDENT = 3'd4,
    MODE_MINUS = 3'd5,
    MODE_SKIP  = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    EV_OPEN  = 3'd0,
    EV_CHAR  = 3'd1,
    EV_CLOSE = 3'd2,
    EV_EOL   = 3'd3,
    EV_ERR   = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    KIND_STR   = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_IDENT = 3'd2,
    KIND_SYM   = 3'd3,
    KIND_END   = 3'd4
  } kind_e;

  localparam logic ERR_UNTERMINATED = 1'b0;
  localparam logic ERR_UNEXPECTED   = 1'b1;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_LPAREN    = 8'h28;
  localparam logic [7:0] CHAR_RPAREN    = 8'h29;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_SEMI      = 8'h3B;

  localparam int unsigned MaxEvents = 5;
  localparam int unsigned CntW = 3;

  // Fields from the lowest bit up: event, kind, character, error code.
  typedef struct packed {
    logic       err;
    logic [7:0] ch;
    kind_e      kind;
    event_e     evt;
  } ev_t;

  typedef struct packed {
    logic [CntW-1:0]            cnt;
    ev_t [MaxEvents-1:0]        evs;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return is_alpha(c) || (c == CHAR_UNDERSCORE);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_COMMA, CHAR_EQUAL, CHAR_STAR, CHAR_SEMI};
  endfunction

  function automatic ev_t mk_ev(input event_e evt, input kind_e kind,
                                input logic [7:0] ch, input logic err);
    ev_t e;
    e.evt  = evt;
    e.kind = kind;
    e.ch   = ch;
    e.err  = err;
    return e;
  endfunction

endpackage

>>> rtl/core/qtt_front.sv
`timescale 1ns / 1ps

module qtt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         char_code_i,
  input  logic               char_valid_i,
  input  logic               end_of_line_i,
  output logic               in_ready_o,
  output logic               push_valid_o,
  output qtt_pkg::bundle_t   push_data_o,
  input  logic               push_ready_i
);

  qtt_pkg::mode_e   lex_mode_q, lex_mode_d;
  qtt_pkg::bundle_t bundle;
  logic             accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  always_comb begin
    logic [qtt_pkg::CntW-1:0] n;
    logic                     run_idle;
    logic [7:0]               c;
    n          = '0;
    run_idle   = 1'b0;
    c          = char_code_i;
    bundle     = '0;
    lex_mode_d = lex_mode_q;

    if (char_valid_i) begin
      case (lex_mode_q)
        qtt_pkg::MODE_STR: begin
          if (c == qtt_pkg::CHAR_BACKSLASH) begin
            lex_mode_d = qtt_pkg::MODE_ESC;
          end else if (c == qtt_pkg::CHAR_QUOTE) begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_STR, 8'h00, 1'b0);
            n = n + 3'd1;
            lex_mode_d = qtt_pkg::MODE_IDLE;
          end else begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_STR, c, 1'b0);
            n = n + 3'd1;
          end
        end
        qtt_pkg::MODE_ESC: begin
          if (!((c == qtt_pkg::CHAR_QUOTE) || (c == qtt_pkg::CHAR_BACKSLASH))) begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_STR,
                                           qtt_pkg::CHAR_BACKSLASH, 1'b0);
            n = n + 3'd1;
          end
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_STR, c, 1'b0);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_STR;
        end
        qtt_pkg::MODE_NUM: begin
          if (qtt_pkg::is_digit(c)) begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_NUM, c, 1'b0);
            n = n + 3'd1;
          end else begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_NUM, 8'h00, 1'b0);
            n = n + 3'd1;
            run_idle = 1'b1;
          end
        end
        qtt_pkg::MODE_IDENT: begin
          if (qtt_pkg::is_word_char(c)) begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_IDENT, c, 1'b0);
            n = n + 3'd1;
          end else begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_IDENT, 8'h00,
                                           1'b0);
            n = n + 3'd1;
            run_idle = 1'b1;
          end
        end
        qtt_pkg::MODE_MINUS: begin
          if (qtt_pkg::is_digit(c)) begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_OPEN, qtt_pkg::KIND_NUM, 8'h00, 1'b0);
            n = n + 3'd1;
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_NUM,
                                           qtt_pkg::CHAR_MINUS, 1'b0);
            n = n + 3'd1;
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_NUM, c, 1'b0);
            n = n + 3'd1;
            lex_mode_d = qtt_pkg::MODE_NUM;
          end else begin
            bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_ERR, qtt_pkg::KIND_STR, 8'h00,
                                           qtt_pkg::ERR_UNEXPECTED);
            n = n + 3'd1;
            lex_mode_d = qtt_pkg::MODE_SKIP;
          end
        end
        qtt_pkg::MODE_SKIP: begin
          lex_mode_d = qtt_pkg::MODE_SKIP;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        if (qtt_pkg::is_space(c)) begin
          lex_mode_d = qtt_pkg::MODE_IDLE;
        end else if (c == qtt_pkg::CHAR_QUOTE) begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_OPEN, qtt_pkg::KIND_STR, 8'h00, 1'b0);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_STR;
        end else if (qtt_pkg::is_digit(c)) begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_OPEN, qtt_pkg::KIND_NUM, 8'h00, 1'b0);
          n = n + 3'd1;
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_NUM, c, 1'b0);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_NUM;
        end else if (c == qtt_pkg::CHAR_MINUS) begin
          lex_mode_d = qtt_pkg::MODE_MINUS;
        end else if (qtt_pkg::is_word_start(c)) begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_OPEN, qtt_pkg::KIND_IDENT, 8'h00, 1'b0);
          n = n + 3'd1;
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_IDENT, c, 1'b0);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_IDENT;
        end else if (qtt_pkg::is_symbol(c)) begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_OPEN, qtt_pkg::KIND_SYM, 8'h00, 1'b0);
          n = n + 3'd1;
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CHAR, qtt_pkg::KIND_SYM, c, 1'b0);
          n = n + 3'd1;
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_SYM, 8'h00, 1'b0);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_IDLE;
        end else begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_ERR, qtt_pkg::KIND_STR, 8'h00,
                                         qtt_pkg::ERR_UNEXPECTED);
          n = n + 3'd1;
          lex_mode_d = qtt_pkg::MODE_SKIP;
        end
      end
    end

    if (end_of_line_i) begin
      case (lex_mode_d)
        qtt_pkg::MODE_STR, qtt_pkg::MODE_ESC: begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_ERR, qtt_pkg::KIND_STR, 8'h00,
                                         qtt_pkg::ERR_UNTERMINATED);
          n = n + 3'd1;
        end
        qtt_pkg::MODE_NUM: begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_NUM, 8'h00, 1'b0);
          n = n + 3'd1;
        end
        qtt_pkg::MODE_IDENT: begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_CLOSE, qtt_pkg::KIND_IDENT, 8'h00, 1'b0);
          n = n + 3'd1;
        end
        qtt_pkg::MODE_MINUS: begin
          bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_ERR, qtt_pkg::KIND_STR, 8'h00,
                                         qtt_pkg::ERR_UNEXPECTED);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      bundle.evs[n] = qtt_pkg::mk_ev(qtt_pkg::EV_EOL, qtt_pkg::KIND_END, 8'h00, 1'b0);
      n = n + 3'd1;
      lex_mode_d = qtt_pkg::MODE_IDLE;
    end

    bundle.cnt = n;
  end

  assign push_valid_o = accept & (bundle.cnt != '0);
  assign push_data_o  = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_mode_q <= qtt_pkg::MODE_IDLE;
    end else if (accept) begin
      lex_mode_q <= lex_mode_d;
    end
  end

endmodule

>>> rtl/core/qtt_fifo.sv
`timescale 1ns / 1ps

module qtt_fifo #(
  parameter int unsigned Width = 78,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] head_data_o,
  output logic             head_valid_o
);

  // Depth must be at least two.
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_en, pop_en;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign push_en      = push_i & ~full_o;
  assign pop_en       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_en && !pop_en) begin
      count_d = count_q + CntW'(1);
    end else if (pop_en && !push_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/qtt_back.sv
`timescale 1ns / 1ps

module qtt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qtt_pkg::bundle_t head_data_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output qtt_pkg::ev_t     out_ev_o,
  output logic             out_last_o,
  input  logic             out_ready_i
);

  logic [qtt_pkg::CntW-1:0] idx_q, idx_d;
  logic                     xfer;

  assign out_valid_o = head_valid_i;
  assign out_ev_o    = head_data_i.evs[idx_q];
  assign out_last_o  = (idx_q == head_data_i.cnt - qtt_pkg::CntW'(1));
  assign xfer        = head_valid_i & out_ready_i;
  assign pop_o       = xfer & out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = out_last_o ? '0 : idx_q + qtt_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> rtl/core/query_text_tokenizer.sv
`timescale 1ns / 1ps

// Streaming tokenizer for query text: one byte per input transfer, with tlast marking the
// end of a line, and one token event per output transfer, with tlast on the final event
// caused by an input. The front end lexes a byte in the cycle it is accepted and stores its
// events (one to five) as one entry of a queue of FifoDepth entries, or nothing if there
// are none; the back end sends one event per cycle while m_axis_tready is high. An input
// that causes n events occupies the output for n transfers, and input is accepted whenever
// the queue has a free entry, so the sustained rate is set by the event count per byte.
module query_text_tokenizer #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // char_code [7:0], char_valid [8], zero fill above.
  input  logic        s_axis_tlast,  // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // event_res [2:0], kind [5:3], char_out [13:6],
                                     // error_code [14], zero fill above.
  output logic        m_axis_tlast   // last
);

  localparam int unsigned BundleW = $bits(qtt_pkg::bundle_t);

  qtt_pkg::bundle_t push_data, head_data;
  logic             push_valid, fifo_full, head_valid, pop;
  logic [BundleW-1:0] head_bits;
  qtt_pkg::ev_t     out_ev;

  qtt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .char_code_i   (s_axis_tdata[7:0]),
    .char_valid_i  (s_axis_tdata[8]),
    .end_of_line_i (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .push_ready_i  (~fifo_full)
  );

  qtt_fifo #(
    .Width (BundleW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_data_i  (push_data),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_data_o  (head_bits),
    .head_valid_o (head_valid)
  );

  assign head_data = qtt_pkg::bundle_t'(head_bits);

  qtt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_data_i  (head_data),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ev_o     (out_ev),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_ev};

  // A line end is always the final event of its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_ev.evt == qtt_pkg::EV_EOL) |-> m_axis_tlast)
    else $error("line end event not marked last");

  // Every accepted end of line produces a queue entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |-> push_valid)
    else $error("end of line produced no events");

  // An empty item produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tdata[8] && !s_axis_tlast |-> !push_valid)
    else $error("empty item produced events");

  // Error events carry kind zero and no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_ev.evt == qtt_pkg::EV_ERR) |->
      (out_ev.kind == qtt_pkg::KIND_STR) && (out_ev.ch == 8'h00))
    else $error("malformed error event");

endmodule
